// File: hw/rtl/rffu_pkg.sv
`timescale 1ns / 1ps

package rffu_pkg;

    // Default queue depth handed to the top level
    localparam int DEPTH_DEF = 8;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_ENQ   = 2'd0,
        ACT_DEQ   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] value;
    } out_item_t;

    // Classified command, as queued for the back end
    typedef struct packed {
        action_t    act;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_OUTER,
        BK_INNER
    } back_state_t;

endpackage

// File: hw/rtl/rffu_ram.sv
`timescale 1ns / 1ps

module rffu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: hw/rtl/rffu_front.sv
`timescale 1ns / 1ps

module rffu_front
    import rffu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    logic vld_reg;
    logic vld_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    assign s_ready = !vld_reg || cmd_ready;

    // Classify: only enqueue carries a byte
    always_comb begin
        vld_next = vld_reg;
        cmd_next = cmd_reg;
        if (s_valid && s_ready) begin
            vld_next     = 1'b1;
            cmd_next.act = action_t'(s_data.action);
            cmd_next.data = (action_t'(s_data.action) == ACT_ENQ) ? s_data.data : 8'd0;
        end else if (cmd_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = vld_reg;
    assign cmd       = cmd_reg;

endmodule

// File: hw/rtl/rffu_cmdq.sv
`timescale 1ns / 1ps

module rffu_cmdq
    import rffu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t               slot_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg;
    logic [CMDQ_AW-1:0] wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg;
    logic [CMDQ_AW-1:0] rd_ptr_next;
    logic [CMDQ_CW-1:0] fill_reg;
    logic [CMDQ_CW-1:0] fill_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = fill_reg != CMDQ_CW'(CMDQ_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hw/rtl/rffu_back.sv
`timescale 1ns / 1ps

module rffu_back
    import rffu_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  cmd_t                     cmd,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic [7:0]               ram_wdata,
    output logic [$clog2(DEPTH)-1:0] ram_raddr_a,
    input  logic [7:0]               ram_rdata_a,
    output logic [$clog2(DEPTH)-1:0] ram_raddr_b,
    input  logic [7:0]               ram_rdata_b
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] p_reg, p_next;
    logic [IDX_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [1:0]       hits_reg, hits_next;
    action_t          act_reg, act_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic       out_free;
    logic       start;
    logic       is_empty;
    logic       is_full;
    logic       eq;
    logic [1:0] hits_inc;
    logic       last_cmp;
    logic       stop;
    logic       unique_hit;
    logic       last_outer;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign out_free   = !out_valid_reg || m_ready;
    assign start      = (state_reg == BK_IDLE) && cmd_valid && out_free;
    assign is_empty   = count_reg == '0;
    assign is_full    = count_reg == CNT_W'(DEPTH);
    assign eq         = ram_rdata_b == ram_rdata_a;
    // saturating match count: 0, 1, or "two or more"
    assign hits_inc   = eq ? ((hits_reg == 2'd0) ? 2'd1 : 2'd2) : hits_reg;
    assign last_cmp   = j_reg == count_reg;
    assign stop       = last_cmp || (hits_inc == 2'd2);
    assign unique_hit = last_cmp && (hits_inc == 2'd1);
    assign last_outer = (i_reg + 1'b1) == count_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (start) begin
                    unique case (cmd.act)
                        ACT_ENQ:   state_next = BK_IDLE;
                        ACT_DEQ,
                        ACT_PEEK:  state_next = is_empty ? BK_IDLE : BK_READ;
                        ACT_QUERY: state_next = is_empty ? BK_IDLE : BK_OUTER;
                        default:   state_next = BK_IDLE;
                    endcase
                end
            end
            BK_READ:  state_next = BK_IDLE;
            BK_OUTER: state_next = BK_INNER;
            BK_INNER: begin
                if (stop) begin
                    state_next = (unique_hit || last_outer) ? BK_IDLE : BK_OUTER;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        hits_next      = hits_reg;
        act_next       = act_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        cmd_ready      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = tail_reg;
        ram_wdata      = cmd.data;
        ram_raddr_a    = (state_reg == BK_IDLE) ? head_reg : p_reg;
        ram_raddr_b    = q_reg;

        unique case (state_reg)
            BK_IDLE: begin
                if (start) begin
                    cmd_ready = 1'b1;
                    act_next  = cmd.act;
                    if (cmd.act == ACT_ENQ) begin
                        out_valid_next = 1'b1;
                        out_next.value = 8'd0;
                        if (is_full) begin
                            out_next.status = ST_FULL;
                        end else begin
                            out_next.status = ST_OK;
                            ram_we          = 1'b1;
                            tail_next       = wrap_inc(tail_reg);
                            count_next      = count_reg + 1'b1;
                        end
                    end else if (is_empty) begin
                        out_valid_next  = 1'b1;
                        out_next.status = ST_EMPTY;
                        out_next.value  = 8'd0;
                    end else begin
                        p_next = head_reg;
                        i_next = '0;
                    end
                end
            end
            BK_READ: begin
                out_valid_next  = 1'b1;
                out_next.status = ST_OK;
                out_next.value  = ram_rdata_a;
                if (act_reg == ACT_DEQ) begin
                    head_next  = wrap_inc(head_reg);
                    count_next = count_reg - 1'b1;
                end
            end
            BK_OUTER: begin
                ram_raddr_b = head_reg;
                q_next      = wrap_inc(head_reg);
                j_next      = CNT_W'(1);
                hits_next   = 2'd0;
            end
            BK_INNER: begin
                q_next    = wrap_inc(q_reg);
                j_next    = j_reg + 1'b1;
                hits_next = hits_inc;
                if (stop) begin
                    if (unique_hit) begin
                        out_valid_next  = 1'b1;
                        out_next.status = ST_OK;
                        out_next.value  = ram_rdata_a;
                    end else if (last_outer) begin
                        out_valid_next  = 1'b1;
                        out_next.status = ST_NONE;
                        out_next.value  = 8'd0;
                    end else begin
                        p_next = wrap_inc(p_reg);
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        p_reg    <= p_next;
        q_reg    <= q_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        hits_reg <= hits_next;
        act_reg  <= act_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: hw/rtl/ring_fifo_first_unique_unit.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake          | Payload
// s_      | in  | s_valid / s_ready  | s_data : in_item_t  {action, data}
// m_      | out | m_valid / m_ready  | m_data : out_item_t {status, value}
//
// Back-end work per item: enqueue, full and empty finish in the idle state;
// dequeue and peek add a read state for the RAM read; query tests candidates in
// turn, each candidate doing at most n = occupancy compares, until a unique one.
// The nested scan over the slot RAM sets the cost of a query.
// Reset: aresetn synchronous, active low; clears pointers, count and handshakes.
// Stalls: front register and a 2-entry command queue keep taking transfers while
// the back end scans or m_ready is low; the back end waits on a held result.

module ring_fifo_first_unique_unit
    import rffu_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int IDX_W = $clog2(DEPTH);

    // front -> command queue
    logic fr_valid;
    logic fr_ready;
    cmd_t fr_cmd;

    // command queue -> back end
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    // slot RAM
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [IDX_W-1:0] ram_raddr_a;
    logic [7:0]       ram_rdata_a;
    logic [IDX_W-1:0] ram_raddr_b;
    logic [7:0]       ram_rdata_b;

    // Accept and classify each transfer
    rffu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd       (fr_cmd)
    );

    // Decouples front from back
    rffu_cmdq u_cmdq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_cmd   (fr_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    // Executes commands against the ring and owns the result register
    rffu_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .cmd         (q_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_rdata_a (ram_rdata_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_b (ram_rdata_b)
    );

    // Ring storage: port A holds the candidate, port B walks the queue
    rffu_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_slots (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import rffu_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 650;
    localparam int CHUNK_ITEMS    = 40;
    // longest query scan plus margin for the tail of the run
    localparam int DRAIN_CYCLES   = 2 * DEPTH * (DEPTH + 1) + 16;
    // receiver hold-off long enough to back up the whole pipeline
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 60;
    // no transfer for this long means the block is hung
    localparam int WATCHDOG_LIMIT = 3000;

    // Tracks the queue contents and the reply owed for every accepted command
    class rffu_tracker;
        localparam int AW = $clog2(DEPTH);
        localparam int CW = $clog2(DEPTH + 1);

        logic [7:0]    slot_mem [DEPTH];
        logic [AW-1:0] rd_ptr;
        logic [AW-1:0] wr_ptr;
        logic [CW-1:0] fill;

        rffu_pkg::out_item_t pending_replies [$];

        int errors;
        int act_cnt [4];
        int st_cnt  [4];

        function new();
            rd_ptr = '0;
            wr_ptr = '0;
            fill   = '0;
            errors = 0;
            foreach (slot_mem[i]) slot_mem[i] = '0;
            foreach (act_cnt[i]) act_cnt[i] = 0;
            foreach (st_cnt[i]) st_cnt[i] = 0;
        endfunction

        function logic [AW-1:0] next_ptr(logic [AW-1:0] p);
            return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
        endfunction

        function void accept_cmd(rffu_pkg::in_item_t cmd);
            rffu_pkg::out_item_t rep;
            logic [7:0]          cand;
            logic [AW-1:0]       p;
            logic [AW-1:0]       q;
            int                  hits;

            rep.status = rffu_pkg::ST_OK;
            rep.value  = '0;
            act_cnt[cmd.action]++;

            if (cmd.action == rffu_pkg::ACT_ENQ) begin
                if (fill == CW'(DEPTH)) begin
                    rep.status = rffu_pkg::ST_FULL;
                end else begin
                    slot_mem[wr_ptr] = cmd.data;
                    wr_ptr = next_ptr(wr_ptr);
                    fill++;
                end
            end else if (fill == '0) begin
                rep.status = rffu_pkg::ST_EMPTY;
            end else begin
                case (cmd.action)
                    rffu_pkg::ACT_DEQ: begin
                        rep.value = slot_mem[rd_ptr];
                        rd_ptr = next_ptr(rd_ptr);
                        fill--;
                    end
                    rffu_pkg::ACT_PEEK: begin
                        rep.value = slot_mem[rd_ptr];
                    end
                    default: begin
                        // oldest entry that occurs exactly once among occupied slots
                        rep.status = rffu_pkg::ST_NONE;
                        p = rd_ptr;
                        for (int i = 0; i < fill; i++) begin
                            cand = slot_mem[p];
                            hits = 0;
                            q = rd_ptr;
                            for (int j = 0; j < fill; j++) begin
                                if (slot_mem[q] == cand) hits++;
                                q = next_ptr(q);
                            end
                            if (hits == 1 && rep.status == rffu_pkg::ST_NONE) begin
                                rep.status = rffu_pkg::ST_OK;
                                rep.value  = cand;
                            end
                            p = next_ptr(p);
                        end
                    end
                endcase
            end

            st_cnt[rep.status]++;
            pending_replies.push_back(rep);
        endfunction

        function void check_reply(rffu_pkg::out_item_t got);
            rffu_pkg::out_item_t want;

            if (pending_replies.size() == 0) begin
                $error("reply with nothing outstanding: status %0d value %0h",
                       got.status, got.value);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.value !== want.value) begin
                $error("value: expected %0h, actual %0h", want.value, got.value);
                errors++;
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    rffu_tracker tracker = new();

    int replies_seen = 0;
    int quiet_cycles = 0;
    int held_cycles  = 0;

    ring_fifo_first_unique_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Monitor: both channels are sampled at the rising edge. The input side is
    // noted first so a same-cycle reply always finds its expectation queued.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) tracker.accept_cmd(s_data);
            if (m_valid && m_ready) begin
                tracker.check_reply(m_data);
                replies_seen++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("ring_fifo_first_unique_unit: mismatch");
                $finish;
            end
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off once the
    // run is under way, so the front register and command queue fill and
    // s_ready drops while the sender keeps offering.
    initial begin : receiver
        int  stall_left;
        int  calm_left;
        int  hold_left;
        bit  hold_done;

        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        m_ready    = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
                held_cycles++;
            end else if (!hold_done && replies_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                held_cycles++;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 19) == 0) begin
                    calm_left = $urandom_range(40, 150);
                end else if ($urandom_range(0, 2) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Offer one command and hold it until the transfer happens
    task automatic drive_cmd(input action_t act, input logic [7:0] byte_in);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_data.action <= act;
        s_data.data   <= byte_in;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid for the requested idle gap; n == 0 leaves back-to-back transfers
    task automatic idle_for(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic send(input action_t act, input logic [7:0] byte_in);
        idle_for(pick_gap());
        drive_cmd(act, byte_in);
    endtask

    initial begin : stimulus
        int         sent;
        int         bias;
        int         r;
        bit         no_gaps;
        logic [7:0] pool [3];
        logic [7:0] byte_in;
        action_t    act;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty queue on every read-type action
        send(ACT_DEQ,   8'hFF);
        send(ACT_PEEK,  8'h00);
        send(ACT_QUERY, 8'hFF);
        // extremes of the byte; query picks the oldest of two unique bytes
        send(ACT_ENQ,   8'h00);
        send(ACT_ENQ,   8'hFF);
        send(ACT_QUERY, 8'h00);
        send(ACT_PEEK,  8'hFF);
        // a repeat knocks out the oldest candidate
        send(ACT_ENQ,   8'h00);
        send(ACT_QUERY, 8'h00);
        // every byte duplicated: no unique byte
        send(ACT_ENQ,   8'hFF);
        send(ACT_QUERY, 8'hFF);
        // fill to DEPTH, then enqueue into a full queue
        send(ACT_ENQ,   8'hAA);
        send(ACT_ENQ,   8'h55);
        send(ACT_ENQ,   8'h0F);
        send(ACT_ENQ,   8'hF0);
        send(ACT_ENQ,   8'h33);
        send(ACT_QUERY, 8'h00);
        // drain everything back out
        repeat (DEPTH) send(ACT_DEQ, 8'h00);

        // Random: chunks leaning toward filling, draining or balanced, with
        // data mostly from a small pool so duplicates are common
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            bias    = $urandom_range(0, 2);
            no_gaps = ($urandom_range(0, 3) == 0);
            foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
            for (int k = 0; k < CHUNK_ITEMS && sent < RANDOM_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                case (bias)
                    0:       act = (r < 55) ? ACT_ENQ : (r < 70) ? ACT_DEQ :
                                   (r < 80) ? ACT_PEEK : ACT_QUERY;
                    1:       act = (r < 20) ? ACT_ENQ : (r < 65) ? ACT_DEQ :
                                   (r < 75) ? ACT_PEEK : ACT_QUERY;
                    default: act = (r < 35) ? ACT_ENQ : (r < 65) ? ACT_DEQ :
                                   (r < 75) ? ACT_PEEK : ACT_QUERY;
                endcase
                if ($urandom_range(0, 99) < 70) byte_in = pool[$urandom_range(0, 2)];
                else byte_in = 8'($urandom_range(0, 255));
                if (!no_gaps) idle_for(pick_gap());
                drive_cmd(act, byte_in);
                sent++;
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // wait out every owed reply, then give the back end time to misbehave
        while (tracker.pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d enqueue, %0d dequeue, %0d peek, %0d unique-query transfers",
                 tracker.act_cnt[ACT_ENQ], tracker.act_cnt[ACT_DEQ],
                 tracker.act_cnt[ACT_PEEK], tracker.act_cnt[ACT_QUERY]);
        $display("replies: %0d ok, %0d full, %0d empty, %0d no-unique; receiver held %0d cycles",
                 tracker.st_cnt[ST_OK], tracker.st_cnt[ST_FULL],
                 tracker.st_cnt[ST_EMPTY], tracker.st_cnt[ST_NONE], held_cycles);
        if (tracker.errors == 0) begin
            $display("ring_fifo_first_unique_unit: match");
        end else begin
            $display("ring_fifo_first_unique_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rffu_pkg.sv
hw/rtl/rffu_ram.sv
hw/rtl/rffu_front.sv
hw/rtl/rffu_cmdq.sv
hw/rtl/rffu_back.sv
hw/rtl/ring_fifo_first_unique_unit.sv
tb/tb.sv
